// File: src/cbp_pkg.sv
// Shared types and constants for the residue combiner and bit packer.
`timescale 1ns / 1ps

package cbp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE      = 2'd2;

    // Reset values, truncated to the limb width where they are used
    localparam logic [27:0] MODULUS_RESET = 28'h7FF_FFFF;
    localparam logic [27:0] INVERSE_RESET = 28'h000_0001;

    // Front sequencer: one-hot
    typedef enum logic [5:0] {
        F_IDLE   = 6'b000001,
        F_REDUCE = 6'b000010,
        F_DIFF   = 6'b000100,
        F_MULMOD = 6'b001000,
        F_PROD   = 6'b010000,
        F_PUSH   = 6'b100000
    } t_front_state;

    // Back packer: one-hot
    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_EMIT = 2'b10
    } t_back_state;

endpackage

// File: src/cbp_front.sv
// Front: accepts residue pairs and rebuilds the value by Garner's method.
`timescale 1ns / 1ps

module cbp_front #(
    parameter int LIMB_WIDTH = 27,
    parameter int WIRE_WIDTH = 54
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [LIMB_WIDTH-1:0] i_residue_low,
    input  logic [LIMB_WIDTH-1:0] i_residue_high,
    input  logic                  i_last,
    input  logic [LIMB_WIDTH-1:0] i_modulus_low,
    input  logic [LIMB_WIDTH-1:0] i_modulus_high,
    input  logic [LIMB_WIDTH-1:0] i_inverse,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output logic [WIRE_WIDTH-1:0] o_value,
    output logic                  o_last
);

    localparam int CW    = (LIMB_WIDTH > 1) ? $clog2(LIMB_WIDTH) : 1;
    localparam int SUM_W = 2 * LIMB_WIDTH + 1;
    localparam int EXT_W = (SUM_W > WIRE_WIDTH) ? SUM_W : WIRE_WIDTH;

    cbp_pkg::t_front_state r_state, n_state;

    logic [LIMB_WIDTH-1:0]   r_rlo, r_rhi;
    logic                    r_last;
    logic [LIMB_WIDTH-1:0]   r_a, r_b, r_d, r_h;
    logic [CW-1:0]           r_cnt;
    logic [2*LIMB_WIDTH-1:0] r_prod;

    logic [LIMB_WIDTH:0] m_ext;
    logic [LIMB_WIDTH:0] a_sh, b_sh, a_red, b_red;
    logic [LIMB_WIDTH:0] d_sum;
    logic [LIMB_WIDTH:0] t_dbl, t_red, u_add, u_red;
    logic [EXT_W-1:0]    sum_ext;
    logic                m_small;

    assign m_ext   = {1'b0, i_modulus_low};
    assign m_small = (i_modulus_low < LIMB_WIDTH'(2));

    always_comb begin
        // restoring reduction, one bit of each residue per cycle
        a_sh  = {r_a, r_rlo[r_cnt]};
        b_sh  = {r_b, r_rhi[r_cnt]};
        a_red = (a_sh >= m_ext) ? (a_sh - m_ext) : a_sh;
        b_red = (b_sh >= m_ext) ? (b_sh - m_ext) : b_sh;
        // difference mod m
        d_sum = (r_a >= r_b) ? ({1'b0, r_a} - {1'b0, r_b})
                             : ({1'b0, r_a} + m_ext - {1'b0, r_b});
        // double-and-add modular multiply, one inverse bit per cycle
        t_dbl = {r_h, 1'b0};
        t_red = (t_dbl >= m_ext) ? (t_dbl - m_ext) : t_dbl;
        u_add = t_red + (i_inverse[r_cnt] ? {1'b0, r_d} : '0);
        u_red = (u_add >= m_ext) ? (u_add - m_ext) : u_add;
        sum_ext = EXT_W'(r_rhi) + EXT_W'(r_prod);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbp_pkg::F_IDLE:   if (i_valid) n_state = cbp_pkg::F_REDUCE;
            cbp_pkg::F_REDUCE: if (r_cnt == '0) n_state = cbp_pkg::F_DIFF;
            cbp_pkg::F_DIFF:   n_state = m_small ? cbp_pkg::F_PROD : cbp_pkg::F_MULMOD;
            cbp_pkg::F_MULMOD: if (r_cnt == '0) n_state = cbp_pkg::F_PROD;
            cbp_pkg::F_PROD:   n_state = cbp_pkg::F_PUSH;
            cbp_pkg::F_PUSH:   if (i_push_ready) n_state = cbp_pkg::F_IDLE;
            default:           n_state = cbp_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbp_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cbp_pkg::F_IDLE: begin
                r_rlo  <= i_residue_low;
                r_rhi  <= i_residue_high;
                r_last <= i_last;
                r_a    <= '0;
                r_b    <= '0;
                r_cnt  <= CW'(LIMB_WIDTH - 1);
            end
            cbp_pkg::F_REDUCE: begin
                r_a   <= a_red[LIMB_WIDTH-1:0];
                r_b   <= b_red[LIMB_WIDTH-1:0];
                r_cnt <= r_cnt - CW'(1);
            end
            cbp_pkg::F_DIFF: begin
                r_d   <= d_sum[LIMB_WIDTH-1:0];
                r_h   <= '0;
                r_cnt <= CW'(LIMB_WIDTH - 1);
            end
            cbp_pkg::F_MULMOD: begin
                r_h   <= u_red[LIMB_WIDTH-1:0];
                r_cnt <= r_cnt - CW'(1);
            end
            cbp_pkg::F_PROD: begin
                r_prod <= i_modulus_high * r_h;
            end
            cbp_pkg::F_PUSH: begin
                r_cnt <= r_cnt;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // final add runs off the product register while the value waits in push
    assign o_ready      = (r_state == cbp_pkg::F_IDLE);
    assign o_push_valid = (r_state == cbp_pkg::F_PUSH);
    assign o_value      = sum_ext[WIRE_WIDTH-1:0];
    assign o_last       = r_last;

endmodule

// File: src/cbp_queue.sv
// Two-entry queue between the front and the back.
`timescale 1ns / 1ps

module cbp_queue #(
    parameter int WIDTH = 55
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_pop_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

// File: src/cbp_back.sv
// Back: appends values MSB first to the bit stream and emits whole bytes.
`timescale 1ns / 1ps

module cbp_back #(
    parameter int WIRE_WIDTH = 54
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  logic [WIRE_WIDTH-1:0] i_value,
    input  logic                  i_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_byte,
    output logic                  o_last
);

    localparam int BW = WIRE_WIDTH + 7;
    localparam int RW = $clog2(BW + 1);

    cbp_pkg::t_back_state r_state, n_state;

    // pending bits sit left aligned at the top of r_buf, zeros below
    logic [BW-1:0] r_buf, n_buf;
    logic [RW-1:0] r_rem, n_rem;
    logic          r_last_item;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic          out_free, emit, done;
    logic [RW-1:0] rem_less;

    assign out_free = !r_out_valid || i_ready;
    assign emit     = (r_state == cbp_pkg::B_EMIT) && out_free;
    assign o_pop    = (r_state == cbp_pkg::B_IDLE) && i_valid;
    assign rem_less = r_rem - RW'(8);

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_rem   = r_rem;
        done    = 1'b0;
        unique case (r_state)
            cbp_pkg::B_IDLE: begin
                if (i_valid) begin
                    n_buf   = r_buf | (BW'(i_value) << (3'd7 - r_rem[2:0]));
                    n_rem   = r_rem + RW'(WIRE_WIDTH);
                    n_state = cbp_pkg::B_EMIT;
                end
            end
            cbp_pkg::B_EMIT: begin
                if (r_rem >= RW'(8)) begin
                    n_buf = r_buf << 8;
                    n_rem = rem_less;
                    done  = (rem_less < RW'(8)) && (!r_last_item || rem_less == '0);
                end else begin
                    // flush the partial byte, zero padded
                    n_buf = '0;
                    n_rem = '0;
                    done  = 1'b1;
                end
                if (!emit) begin
                    n_buf = r_buf;
                    n_rem = r_rem;
                end else if (done) begin
                    n_state = cbp_pkg::B_IDLE;
                end
            end
            default: n_state = cbp_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbp_pkg::B_IDLE;
            r_buf       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_buf   <= n_buf;
            r_rem   <= n_rem;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_last_item <= i_last;
        if (emit) begin
            r_out_byte <= r_buf[BW-1 -: 8];
            r_out_last <= done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

// File: src/crt_combine_bit_packer_core.sv
// Top level: two-modulus residue combiner feeding an MSB-first byte packer.
`timescale 1ns / 1ps
//
// Slave stream: one beat per coefficient. tdata carries residue_low in the low
// LIMB_WIDTH bits and residue_high above it; tlast marks the final coefficient.
// Master stream: one beat per packed byte. tdata is the byte, tlast is high on
// the final byte caused by an input beat.
// Config port: write i_cfg_wdata to register i_cfg_index when i_cfg_we is high
// (0 modulus_low, 1 modulus_high, 2 inverse of modulus_high mod modulus_low).
// Write only while the block is idle.
// The front takes one coefficient at a time; the modular reduction and the
// modular multiply are bit-serial, and with modulus_low below 2 the multiply
// is skipped. A taken beat passes the reduce, difference, multiply, product
// and push states, the queue and the back's load before its first byte is
// offered. The back loads a value while idle, then emits its bytes, holding
// while the output beat is not taken; it pops no new value until its last
// byte is emitted.
// A two-entry queue sits between them, so the front keeps working while the
// master side stalls until the queue is full; a stalled output beat holds its
// byte until taken. Reset (synchronous, active low) clears the pending bits
// and loads the default registers.
//
module crt_combine_bit_packer_core #(
    parameter int WIRE_WIDTH = 54,
    parameter int LIMB_WIDTH = 27
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // residue_low, residue_high, zero fill
    input  logic [((2*LIMB_WIDTH+7)/8)*8-1:0]    i_s_tdata,
    input  logic                                 i_s_tlast,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // out_byte
    output logic [7:0]                           o_m_tdata,
    output logic                                 o_m_tlast,
    input  logic                                 i_cfg_we,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [LIMB_WIDTH-1:0]                i_cfg_wdata
);

    logic [LIMB_WIDTH-1:0] r_modulus_low, r_modulus_high, r_inverse;

    logic                  push_valid, push_ready;
    logic [WIRE_WIDTH-1:0] push_value;
    logic                  push_last;
    logic                  pop_valid, pop;
    logic [WIRE_WIDTH:0]   pop_data;

    // Config registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus_low  <= LIMB_WIDTH'(cbp_pkg::MODULUS_RESET);
            r_modulus_high <= LIMB_WIDTH'(cbp_pkg::MODULUS_RESET);
            r_inverse      <= LIMB_WIDTH'(cbp_pkg::INVERSE_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbp_pkg::CFG_MODULUS_LOW:  r_modulus_low  <= i_cfg_wdata;
                cbp_pkg::CFG_MODULUS_HIGH: r_modulus_high <= i_cfg_wdata;
                cbp_pkg::CFG_INVERSE:      r_inverse      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front: Garner reconstruction, one beat in flight
    cbp_front #(
        .LIMB_WIDTH (LIMB_WIDTH),
        .WIRE_WIDTH (WIRE_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_residue_low  (i_s_tdata[LIMB_WIDTH-1:0]),
        .i_residue_high (i_s_tdata[2*LIMB_WIDTH-1:LIMB_WIDTH]),
        .i_last         (i_s_tlast),
        .i_modulus_low  (r_modulus_low),
        .i_modulus_high (r_modulus_high),
        .i_inverse      (r_inverse),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_value        (push_value),
        .o_last         (push_last)
    );

    // Queue decouples reconstruction from byte emission
    cbp_queue #(
        .WIDTH (WIRE_WIDTH + 1)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .o_push_ready (push_ready),
        .i_data       ({push_last, push_value}),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_data       (pop_data)
    );

    // Back: bit packer with a registered output beat
    cbp_back #(
        .WIRE_WIDTH (WIRE_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop_valid),
        .o_pop   (pop),
        .i_value (pop_data[WIRE_WIDTH-1:0]),
        .i_last  (pop_data[WIRE_WIDTH]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

endmodule
